/* sv/minifloat_format_converter_macros.svh */
// Assertion macros shared by the minifloat format converter RTL.
`ifndef MINIFLOAT_FORMAT_CONVERTER_MACROS_SVH
`define MINIFLOAT_FORMAT_CONVERTER_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define MFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define MFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mfc_pkg.sv */
// Package with the mode codes and format constants of the minifloat converter.
`default_nettype none
package mfc_pkg;

    localparam int unsigned SRC_W  = 32;
    localparam int unsigned MODE_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_FP8_TO_FP16  = 3'd0,
        MODE_FP16_TO_FP32 = 3'd1,
        MODE_FP16_TO_FP8  = 3'd2,
        MODE_FP32_TO_FP16 = 3'd3,
        MODE_FP8_TO_FP32  = 3'd4,
        MODE_FP32_TO_FP8  = 3'd5
    } mode_t;

    localparam logic [7:0]  FP8_NEG_ZERO     = 8'h80;
    localparam logic [15:0] FP8_NEG_ZERO_MAP = 16'h7F00;
    localparam logic [14:0] FP16_INF_MAG     = 15'h7C00;
    localparam logic [6:0]  FP8_MAX_MAG      = 7'h7F;
    localparam logic [4:0]  FP8_REBIAS       = 5'd8;    // 15 - 7
    localparam logic [7:0]  FP16_REBIAS      = 8'd112;  // 127 - 15
    localparam logic [7:0]  FP16_EXP_LIMIT   = 8'd31;

endpackage
`default_nettype wire

/* sv/mfc_in_if.sv */
// Input channel interface: valid/ready handshake with mode and source bits.
`default_nettype none
interface mfc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] source_bits;

    modport source (output valid, output mode, output source_bits, input ready);
    modport sink (input valid, input mode, input source_bits, output ready);
endinterface
`default_nettype wire

/* sv/mfc_out_if.sv */
// Output channel interface: valid/ready handshake with the converted bits.
`default_nettype none
interface mfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] converted_bits;

    modport source (output valid, output converted_bits, input ready);
    modport sink (input valid, input converted_bits, output ready);
endinterface
`default_nettype wire

/* sv/mfc_convert.sv */
// Combinational bit-field conversion between FP8, binary16 and binary32.
`default_nettype none
module mfc_convert (
    input  mfc_pkg::mode_t mode,
    input  logic [31:0]    source_bits,
    output logic [31:0]    converted_bits
);

    function automatic logic [15:0] fp8_to_fp16(input logic [7:0] b);
        logic [15:0] r;
        if (b == 8'h00)
        begin
            r = 16'h0000;
        end
        else if (b == mfc_pkg::FP8_NEG_ZERO)
        begin
            r = mfc_pkg::FP8_NEG_ZERO_MAP;
        end
        else
        begin
            r = {b[7], {1'b0, b[6:3]} + mfc_pkg::FP8_REBIAS, b[2:0], 7'b0};
        end
        return r;
    endfunction

    function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
        logic [31:0] r;
        if (h[14:10] == 5'd0)
        begin
            r = 32'h0;
        end
        else
        begin
            r = {h[15], {3'b0, h[14:10]} + mfc_pkg::FP16_REBIAS, h[9:0], 13'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] fp16_to_fp8(input logic [15:0] h);
        logic [4:0] ex;
        logic [7:0] v;
        ex = h[14:10] - mfc_pkg::FP8_REBIAS;
        v  = {h[15], ex[3:0], h[9:7]};
        if (h[14:10] < mfc_pkg::FP8_REBIAS)
        begin
            v = 8'h00;
        end
        else if (ex > 5'd15)
        begin
            v = {h[15], mfc_pkg::FP8_MAX_MAG};
        end
        else
        begin
            if (v == mfc_pkg::FP8_NEG_ZERO)
            begin
                v = 8'h00;
            end
            // Round up unless the carry would spill into the sign bit.
            if (h[6] && (v[6:0] != mfc_pkg::FP8_MAX_MAG))
            begin
                v = v + 8'd1;
            end
        end
        return v;
    endfunction

    function automatic logic [15:0] fp32_to_fp16(input logic [31:0] s);
        logic [7:0]  ex;
        logic [15:0] r;
        ex = s[30:23] - mfc_pkg::FP16_REBIAS;
        if (s[30:23] < mfc_pkg::FP16_REBIAS)
        begin
            r = 16'h0000;
        end
        else if (ex >= mfc_pkg::FP16_EXP_LIMIT)
        begin
            r = {s[31], mfc_pkg::FP16_INF_MAG};
        end
        else
        begin
            r = {s[31], ex[4:0], s[22:13]};
        end
        return r;
    endfunction

    always_comb
    begin
        unique case (mode)
            mfc_pkg::MODE_FP8_TO_FP16:  converted_bits = {16'b0, fp8_to_fp16(source_bits[7:0])};
            mfc_pkg::MODE_FP16_TO_FP32: converted_bits = fp16_to_fp32(source_bits[15:0]);
            mfc_pkg::MODE_FP16_TO_FP8:  converted_bits = {24'b0, fp16_to_fp8(source_bits[15:0])};
            mfc_pkg::MODE_FP32_TO_FP16: converted_bits = {16'b0, fp32_to_fp16(source_bits)};
            mfc_pkg::MODE_FP8_TO_FP32:
                converted_bits = fp16_to_fp32(fp8_to_fp16(source_bits[7:0]));
            mfc_pkg::MODE_FP32_TO_FP8:
                converted_bits = {24'b0, fp16_to_fp8(fp32_to_fp16(source_bits))};
            default:                    converted_bits = 32'h0;
        endcase
    end

endmodule
`default_nettype wire

/* sv/minifloat_format_converter.sv */
// Top level of the minifloat format converter: input register, conversion, result register.
// The converter accepts one transfer per clock when the output is not stalled and returns
// exactly one result transfer per input, in order. Each item is captured in an input
// register, converted by a short combinational bit-field path (FP8 to binary32 and binary32
// to FP8 chain through binary16 within that same path), and held in a result register
// until the downstream side takes it. Throughput of one item per cycle with no output
// stall is set by that single conversion path; the input register can still take one item
// while a finished result waits, so two items can be in flight. Modes 6 and 7 return zero.
`default_nettype none
module minifloat_format_converter (
    input  logic        clk,
    input  logic        rst_n,
    mfc_in_if.sink      in_ch,
    mfc_out_if.source   out_ch
);

    // Input stage.
    logic           s1_valid_reg;
    logic           s1_valid_next;
    mfc_pkg::mode_t s1_mode_reg;
    logic [31:0]    s1_src_reg;

    // Result stage.
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [31:0]    out_data_reg;

    logic           out_load;
    logic           in_take;
    logic [31:0]    conv_result;

    // The result register is free when empty or being drained in this cycle.
    assign out_load    = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || out_load;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= mfc_pkg::mode_t'(in_ch.mode);
            s1_src_reg  <= in_ch.source_bits;
        end
        if (out_load)
        begin
            out_data_reg <= conv_result;
        end
    end

    mfc_convert u_convert (
        .mode           (s1_mode_reg),
        .source_bits    (s1_src_reg),
        .converted_bits (conv_result)
    );

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.converted_bits = out_data_reg;

`include "minifloat_format_converter_macros.svh"

    // A captured item that cannot move on must stay put with its payload intact.
    `MFC_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !out_load && !in_take,
        s1_valid_reg && $stable(s1_src_reg) && $stable(s1_mode_reg), "input stage lost an item")

    // A result waiting on a stalled output must not be dropped.
    `MFC_ASSERT_NEXT(a_out_hold, out_valid_reg && !out_ch.ready,
        out_valid_reg && $stable(out_data_reg), "stalled result was dropped or changed")

    // An accepted transfer is always held in the input stage in the next cycle.
    `MFC_ASSERT_NEXT(a_take_lands, in_take, s1_valid_reg, "accepted transfer not captured")

    // FP8 results leave the upper 24 bits clear.
    `MFC_ASSERT_NEXT(a_fp8_upper_zero,
        out_load && (s1_mode_reg == mfc_pkg::MODE_FP16_TO_FP8 ||
                     s1_mode_reg == mfc_pkg::MODE_FP32_TO_FP8),
        out_data_reg[31:8] == 24'h0, "FP8 result has upper bits set")

    // The input side is never refused while the input stage is empty.
    `MFC_ASSERT_SAME(a_ready_when_empty, !s1_valid_reg, in_ch.ready,
        "input refused while input stage empty")

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the minifloat format converter: directed and random conversions with stalls.
`timescale 1ns / 100ps
module tb_top;

    // Codes outside the enum still reach the block; they must convert to zero.
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    // Rebias offsets and fixed bit patterns of the conversions, kept apart from the
    // package so that a wrong constant in the design cannot hide in the prediction.
    localparam logic [4:0]  HALF_FROM_FP8_BIAS    = 5'd8;
    localparam logic [7:0]  SINGLE_FROM_HALF_BIAS = 8'd112;
    localparam logic [15:0] FP8_MINUS_ZERO_WIDE   = 16'h7F00;
    localparam logic [14:0] HALF_INF_MAGNITUDE    = 15'h7C00;

    // Idle cycles in which no transfer happens on either channel before the run is
    // declared hung. The longest legal quiet stretch is the long receiver hold-off.
    localparam int          HANG_LIMIT        = 5000;
    localparam int          LONG_HOLD_CYCLES  = 300;
    localparam int          SETTLE_CYCLES     = 20;

    logic clk;
    logic rst_n;

    mfc_in_if  in_ch ();
    mfc_out_if out_ch ();

    minifloat_format_converter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Converted values still owed by the block, oldest first.
    logic [31:0] pending_conversions[$];
    int          mismatch_count;
    int          quiet_cycles;

    // Idle control shared by the sender task and the receiver process. When a
    // no-idle flag is set that side never inserts a gap, giving full-rate stretches.
    bit          sender_no_idle;
    bit          receiver_no_idle;
    int          receiver_hold_request;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Bit-exact prediction of each conversion direction.
    // ------------------------------------------------------------------

    // FP8 to binary16. Zero stays zero, and the FP8 negative zero pattern maps to a
    // fixed binary16 pattern rather than to a signed zero.
    function automatic logic [15:0] widen_fp8(input logic [7:0] b);
        if (b == 8'h00)
            return 16'h0000;
        if (b == 8'h80)
            return FP8_MINUS_ZERO_WIDE;
        return {b[7], {1'b0, b[6:3]} + HALF_FROM_FP8_BIAS, b[2:0], 7'b0};
    endfunction

    // Binary16 to binary32. Exponent zero collapses to +0 whatever the sign and the
    // fraction; exponent 31 is rebiased like any other exponent.
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [7:0] e8;
        if (h[14:10] == 5'd0)
            return 32'h0000_0000;
        e8 = {3'b000, h[14:10]} + SINGLE_FROM_HALF_BIAS;
        return {h[15], e8, h[9:0], 13'b0};
    endfunction

    // Binary16 to FP8 with truncation, saturation and the one-bit round-up.
    function automatic logic [7:0] narrow_half_to_fp8(input logic [15:0] h);
        logic [4:0] ex;
        logic [7:0] v;
        if (h[14:10] < HALF_FROM_FP8_BIAS)
            return 8'h00;
        ex = h[14:10] - HALF_FROM_FP8_BIAS;
        if (ex > 5'd15)
            return {h[15], 7'h7F};
        v = {h[15], ex[3:0], h[9:7]};
        // A negative zero result is folded to positive zero before rounding.
        if (v == 8'h80)
            v = 8'h00;
        // The round-up carry is dropped whenever it would ripple into the sign bit.
        if (h[6] && (v[6:0] != 7'h7F))
            v = v + 8'd1;
        return v;
    endfunction

    // Binary32 to binary16 by truncation; underflow gives zero, overflow a signed
    // infinity.
    function automatic logic [15:0] narrow_single_to_half(input logic [31:0] s);
        logic [7:0] ex;
        if (s[30:23] < SINGLE_FROM_HALF_BIAS)
            return 16'h0000;
        ex = s[30:23] - SINGLE_FROM_HALF_BIAS;
        if (ex >= 8'd31)
            return {s[31], HALF_INF_MAGNITUDE};
        return {s[31], ex[4:0], s[22:13]};
    endfunction

    function automatic logic [31:0] predict_conversion(input logic [2:0] mode,
                                                       input logic [31:0] src);
        case (mode)
            mfc_pkg::MODE_FP8_TO_FP16:  return {16'b0, widen_fp8(src[7:0])};
            mfc_pkg::MODE_FP16_TO_FP32: return widen_half(src[15:0]);
            mfc_pkg::MODE_FP16_TO_FP8:  return {24'b0, narrow_half_to_fp8(src[15:0])};
            mfc_pkg::MODE_FP32_TO_FP16: return {16'b0, narrow_single_to_half(src)};
            mfc_pkg::MODE_FP8_TO_FP32:  return widen_half(widen_fp8(src[7:0]));
            mfc_pkg::MODE_FP32_TO_FP8:
                return {24'b0, narrow_half_to_fp8(narrow_single_to_half(src))};
            default:                    return 32'h0000_0000;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Transfer monitor and result checker. Both channels are sampled at the rising
    // edge, where every input was set half a period earlier. The result is checked
    // before the new expectation is queued; the block's latency keeps the two apart.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_conversions.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_ch.converted_bits);
                    mismatch_count++;
                end
                else if (out_ch.converted_bits !== pending_conversions[0])
                begin
                    $display("%0t: converted_bits mismatch, expected %h, actual %h",
                             $time, pending_conversions[0], out_ch.converted_bits);
                    mismatch_count++;
                    void'(pending_conversions.pop_front());
                end
                else
                begin
                    void'(pending_conversions.pop_front());
                end
            end
            if (in_ch.valid && in_ch.ready)
                pending_conversions.push_back(predict_conversion(in_ch.mode,
                                                                 in_ch.source_bits));
        end
    end

    // Watchdog: any transfer on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Each result waits a random number of cycles with ready low unless a
    // full-rate stretch is on. A hold-off request lowers ready for a long stretch so
    // that both internal registers fill and the block stalls its input.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (receiver_hold_request > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (receiver_hold_request) @(negedge clk);
                receiver_hold_request = 0;
            end
            stall = receiver_no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Sender. Called at a falling edge, it returns at the falling edge after the
    // transfer with valid still high, so back-to-back items keep valid up.
    // ------------------------------------------------------------------
    task automatic send_conversion(input logic [2:0] mode, input logic [31:0] src);
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= mode;
        in_ch.source_bits <= src;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic stop_sending();
        in_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        while (pending_conversions.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Random source bits; for binary16 half and for binary32 three quarters of the time, the
    // exponent is pulled toward the underflow and overflow boundaries of the chosen direction.
    function automatic logic [31:0] random_source(input logic [2:0] mode);
        logic [31:0] src;
        src = $urandom;
        case (mode) inside
            mfc_pkg::MODE_FP8_TO_FP16, mfc_pkg::MODE_FP8_TO_FP32:
            begin
                if ($urandom_range(0, 7) == 0)
                    src[7:0] = $urandom_range(0, 1) ? 8'h80 : 8'h00;
            end
            mfc_pkg::MODE_FP16_TO_FP32, mfc_pkg::MODE_FP16_TO_FP8:
            begin
                if ($urandom_range(0, 1) == 1)
                    src[14:10] = 5'($urandom_range(6, 25));
                if ($urandom_range(0, 15) == 0)
                    src[14:10] = $urandom_range(0, 1) ? 5'd31 : 5'd0;
            end
            mfc_pkg::MODE_FP32_TO_FP16, mfc_pkg::MODE_FP32_TO_FP8:
            begin
                if ($urandom_range(0, 3) != 0)
                    src[30:23] = 8'($urandom_range(105, 150));
            end
            default:
            begin
            end
        endcase
        return src;
    endfunction

    function automatic logic [2:0] random_mode();
        if ($urandom_range(0, 49) == 0)
            return $urandom_range(0, 1) ? MODE_SPARE_7 : MODE_SPARE_6;
        return 3'($urandom_range(0, 5));
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Field extremes, every direction and each corner case of the conversions.
    task automatic test_directed_corners();
        // FP8 zero, negative zero, largest magnitudes, and ignored upper bits.
        send_conversion(mfc_pkg::MODE_FP8_TO_FP16, 32'h0000_0000);
        send_conversion(mfc_pkg::MODE_FP8_TO_FP16, 32'h0000_0080);
        send_conversion(mfc_pkg::MODE_FP8_TO_FP16, 32'h0000_007F);
        send_conversion(mfc_pkg::MODE_FP8_TO_FP16, 32'hFFFF_FFFF);
        // Binary16 exponent zero with sign and fraction set, exponent 31, upper bits.
        send_conversion(mfc_pkg::MODE_FP16_TO_FP32, 32'h0000_83FF);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP32, 32'h0000_7C00);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP32, 32'hFFFF_FFFF);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP32, 32'h0000_3C00);
        // Binary16 to FP8: underflow edge, smallest exponent, negative zero fold with
        // and without round-up, overflow of both signs, and blocked carries.
        send_conversion(mfc_pkg::MODE_FP16_TO_FP8, 32'h0000_1FFF);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP8, 32'h0000_2000);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP8, 32'h0000_A000);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP8, 32'hFFFF_A040);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP8, 32'h0000_7C00);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP8, 32'h0000_FC00);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP8, 32'h0000_5FC0);
        send_conversion(mfc_pkg::MODE_FP16_TO_FP8, 32'h0000_DFC0);
        // Binary32 to binary16: underflow edge, smallest exponent, largest finite,
        // overflow to infinity of both signs.
        send_conversion(mfc_pkg::MODE_FP32_TO_FP16, 32'h37FF_FFFF);
        send_conversion(mfc_pkg::MODE_FP32_TO_FP16, 32'h3800_0000);
        send_conversion(mfc_pkg::MODE_FP32_TO_FP16, 32'h477F_E000);
        send_conversion(mfc_pkg::MODE_FP32_TO_FP16, 32'h4780_0000);
        send_conversion(mfc_pkg::MODE_FP32_TO_FP16, 32'hFF80_0000);
        // Chained directions, then the two codes outside the enum.
        send_conversion(mfc_pkg::MODE_FP8_TO_FP32, 32'hFFFF_FF80);
        send_conversion(mfc_pkg::MODE_FP8_TO_FP32, 32'h0000_00FF);
        send_conversion(mfc_pkg::MODE_FP32_TO_FP8, 32'hBF80_0000);
        send_conversion(mfc_pkg::MODE_FP32_TO_FP8, 32'h7F7F_FFFF);
        send_conversion(MODE_SPARE_6, 32'hFFFF_FFFF);
        send_conversion(MODE_SPARE_7, 32'hFFFF_FFFF);
    endtask

    // Bulk random conversions in blocks, each block with its own idle pattern so that
    // full-rate stretches alternate with sparse traffic on either side.
    task automatic test_random_conversions(input int count);
        logic [2:0] mode;
        for (int i = 0; i < count; i++)
        begin
            if (i % 150 == 0)
            begin
                sender_no_idle   = ($urandom_range(0, 3) == 0);
                receiver_no_idle = ($urandom_range(0, 3) == 0);
            end
            mode = random_mode();
            send_conversion(mode, random_source(mode));
        end
        sender_no_idle   = 1'b0;
        receiver_no_idle = 1'b0;
    endtask

    // The receiver holds off for a long stretch while the sender offers items
    // back to back, so the block fills and has to stall its input.
    task automatic test_output_backpressure();
        logic [2:0] mode;
        sender_no_idle        = 1'b1;
        receiver_hold_request = LONG_HOLD_CYCLES;
        for (int i = 0; i < 60; i++)
        begin
            mode = random_mode();
            send_conversion(mode, random_source(mode));
        end
        sender_no_idle = 1'b0;
    endtask

    // The sender stops until every result has arrived, then resumes.
    task automatic test_drain_and_resume();
        logic [2:0] mode;
        for (int i = 0; i < 40; i++)
        begin
            mode = random_mode();
            send_conversion(mode, random_source(mode));
        end
        stop_sending();
        wait_for_drain();
        for (int i = 0; i < 40; i++)
        begin
            mode = random_mode();
            send_conversion(mode, random_source(mode));
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.mode            = mfc_pkg::MODE_FP8_TO_FP16;
        in_ch.source_bits     = 32'h0000_0000;
        mismatch_count        = 0;
        quiet_cycles          = 0;
        sender_no_idle        = 1'b0;
        receiver_no_idle      = 1'b0;
        receiver_hold_request = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_corners();
        test_random_conversions(700);
        test_output_backpressure();
        test_drain_and_resume();
        test_random_conversions(650);

        stop_sending();
        wait_for_drain();
        // A few more cycles catch any stray result the block might still emit.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_conversions.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/mfc_pkg.sv
sv/mfc_in_if.sv
sv/mfc_out_if.sv
sv/mfc_convert.sv
sv/minifloat_format_converter.sv
sim/tb_top.sv
